FILE: src/pem_pkg.sv
package pem_pkg;

    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_INDEX_W      = 1;
    localparam int ROW_W            = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int GX_W   = 11;
    localparam int SQ_W   = 21;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                   border;
        logic                   frame_end;
        logic signed [GX_W-1:0] gx;
        logic signed [GX_W-1:0] gy;
    } job_t;

    function automatic logic [7:0] div3(input logic [7:0] x);
        logic [16:0] prod;
        prod = 17'(x) * 17'd171;
        return prod[16:9];
    endfunction

endpackage

FILE: src/pem_front.sv
module pem_front
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   operation,
    input  logic [7:0]             chan_blue,
    input  logic [7:0]             chan_green,
    input  logic [7:0]             chan_red,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [QLVL_W-1:0]      q_level,
    output logic                   job_push,
    output job_t                   job
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);
    localparam int CMP_W  = WID_W + 2;
    localparam int HCMP_W = CFG_DATA_W + 1;
    localparam logic [WID_W-1:0] W_MAX   = WID_W'(MAX_WIDTH);
    localparam logic [WID_W-1:0] W_MIN   = WID_W'(3);
    localparam logic [WID_W-1:0] W_RESET =
        (FRAME_WIDTH_RST > MAX_WIDTH) ? W_MAX : WID_W'(FRAME_WIDTH_RST);
    localparam logic [CFG_DATA_W-1:0] H_RESET = CFG_DATA_W'(FRAME_HEIGHT_RST);
    localparam logic [CFG_DATA_W-1:0] H_MAX   = CFG_DATA_W'(HEIGHT_LIMIT);
    localparam logic [CFG_DATA_W-1:0] H_MIN   = CFG_DATA_W'(3);

    logic [7:0] upper_mem  [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];

    logic [WID_W-1:0]      w_reg, w_next;
    logic [CFG_DATA_W-1:0] h_reg, h_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [WID_W-1:0]      fill_reg, fill_next;
    logic                  stg_valid_reg;
    logic                  stg_flush_reg;
    logic [7:0]            stg_gray_reg;
    logic [COL_W-1:0]      stg_col_reg;
    logic [7:0]            upper_rd_reg;
    logic [7:0]            middle_rd_reg;
    logic [7:0]            window_reg [9];
    logic [7:0]            window_next [9];

    logic                  accept;
    logic                  pixel_in;
    logic [7:0]            gray;
    logic                  stg_pixel;
    logic                  line_valid;
    logic [7:0]            upper_val;
    logic [7:0]            middle_val;
    logic [9:0]            left_sum, right_sum, top_sum, bottom_sum;
    logic [PEND_W-1:0]     pend_inc;
    logic                  emit;
    logic                  use_window;
    logic                  inner;
    logic                  restart;
    logic [WID_W-1:0]      cfg_w;
    logic [CFG_DATA_W-1:0] cfg_h;

    assign full     = ({1'b0, q_level} + (QLVL_W + 1)'(stg_valid_reg)) >= (QLVL_W + 1)'(QDEPTH);
    assign accept   = push && !full;
    assign pixel_in = (operation == OP_PIXEL);
    assign gray     = 8'(9'(div3(chan_blue)) + 9'(div3(chan_green)) + 9'(div3(chan_red)));

    assign stg_pixel  = stg_valid_reg && (stg_flush_reg == OP_PIXEL);
    assign line_valid = WID_W'(stg_col_reg) < fill_reg;
    assign upper_val  = line_valid ? upper_rd_reg : 8'd0;
    assign middle_val = line_valid ? middle_rd_reg : 8'd0;

    // line stores
    always_ff @(posedge clk)
    begin
        if (accept && pixel_in)
        begin
            upper_rd_reg  <= upper_mem[in_col_reg];
            middle_rd_reg <= middle_mem[in_col_reg];
        end
        if (stg_pixel)
        begin
            upper_mem[stg_col_reg]  <= middle_val;
            middle_mem[stg_col_reg] <= stg_gray_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_gray_reg <= gray;
        stg_col_reg  <= in_col_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            window_next[k] = window_reg[k];
        end
        if (stg_pixel)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_next[k * 3]     = window_reg[k * 3 + 1];
                window_next[k * 3 + 1] = window_reg[k * 3 + 2];
            end
            window_next[2] = upper_val;
            window_next[5] = middle_val;
            window_next[8] = stg_gray_reg;
        end
    end

    assign left_sum   = 10'(window_next[0]) + 10'(window_next[3]) + 10'(window_next[6]);
    assign right_sum  = 10'(window_next[2]) + 10'(window_next[5]) + 10'(window_next[8]);
    assign top_sum    = 10'(window_next[0]) + 10'(window_next[1]) + 10'(window_next[2]);
    assign bottom_sum = 10'(window_next[6]) + 10'(window_next[7]) + 10'(window_next[8]);

    assign inner = (out_col_reg != '0)
                && (CMP_W'(out_col_reg) + CMP_W'(2) <= CMP_W'(w_reg))
                && (out_row_reg != '0)
                && (HCMP_W'(out_row_reg) + HCMP_W'(2) <= HCMP_W'(h_reg));

    assign pend_inc = pend_reg + PEND_W'(1);

    // clamp of configuration values
    always_comb
    begin
        if (cfg_data < CFG_DATA_W'(3))
            cfg_w = W_MIN;
        else if (32'(cfg_data) > MAX_WIDTH)
            cfg_w = W_MAX;
        else
            cfg_w = WID_W'(cfg_data);
        if (cfg_data < H_MIN)
            cfg_h = H_MIN;
        else if (cfg_data > H_MAX)
            cfg_h = H_MAX;
        else
            cfg_h = cfg_data;
    end

    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        fill_next    = fill_reg;
        emit         = 1'b0;
        use_window   = 1'b0;
        restart      = 1'b0;

        if (accept && pixel_in)
        begin
            if (CMP_W'(in_col_reg) + CMP_W'(1) >= CMP_W'(w_reg))
                in_col_next = '0;
            else
                in_col_next = in_col_reg + COL_W'(1);
        end

        if (stg_pixel)
        begin
            if (WID_W'(stg_col_reg) == fill_reg)
                fill_next = fill_reg + WID_W'(1);
            use_window = 1'b1;
            if (pend_inc >= PEND_W'(w_reg) + PEND_W'(2))
                emit = 1'b1;
            else
                pend_next = pend_inc;
        end
        else if (stg_valid_reg && pend_reg != '0)
        begin
            emit      = 1'b1;
            pend_next = pend_reg - PEND_W'(1);
        end

        if (emit)
        begin
            if (CMP_W'(out_col_reg) + CMP_W'(1) >= CMP_W'(w_reg))
            begin
                out_col_next = '0;
                if (HCMP_W'(out_row_reg) + HCMP_W'(1) >= HCMP_W'(h_reg))
                    out_row_next = '0;
                else
                    out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    w_next  = cfg_w;
                    restart = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    h_next  = cfg_h;
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        if (restart)
        begin
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
        end
    end

    assign job_push      = emit;
    assign job.border    = !(inner && use_window);
    assign job.frame_end = (CMP_W'(out_col_reg) + CMP_W'(1) == CMP_W'(w_reg))
                        && (HCMP_W'(out_row_reg) + HCMP_W'(1) == HCMP_W'(h_reg));
    assign job.gx        = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
    assign job.gy        = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= W_RESET;
            h_reg         <= H_RESET;
            in_col_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pend_reg      <= '0;
            fill_reg      <= '0;
            stg_valid_reg <= 1'b0;
            stg_flush_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                window_reg[k] <= 8'd0;
            end
        end
        else
        begin
            w_reg         <= w_next;
            h_reg         <= h_next;
            in_col_reg    <= in_col_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            pend_reg      <= pend_next;
            fill_reg      <= fill_next;
            stg_valid_reg <= accept;
            stg_flush_reg <= operation;
            for (int k = 0; k < 9; k++)
            begin
                window_reg[k] <= window_next[k];
            end
        end
    end

endmodule

FILE: src/pem_queue.sv
module pem_queue
    import pem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  job_t              wr_job,
    input  logic              rd_en,
    output job_t              rd_job,
    output logic              empty,
    output logic [QLVL_W-1:0] level
);

    job_t               slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0]  level_reg, level_next;
    logic               do_wr;
    logic               do_rd;

    assign empty  = (level_reg == '0);
    assign level  = level_reg;
    assign rd_job = slot_reg[rd_ptr_reg];
    assign do_wr  = wr_en && (level_reg != QLVL_W'(QDEPTH));
    assign do_rd  = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + QLVL_W'(do_wr) - QLVL_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

FILE: src/pem_back.sv
module pem_back
    import pem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_empty,
    input  job_t       job_in,
    output logic       job_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_byte3,
    output logic       frame_end
);

    localparam logic [7:0] BORDER0 = 8'd255;
    localparam logic [7:0] BORDER1 = 8'd201;
    localparam logic [7:0] BORDER2 = 8'd175;
    localparam logic [7:0] BORDER3 = 8'd158;

    typedef enum logic [3:0] {
        BK_IDLE   = 4'b0001,
        BK_SQUARE = 4'b0010,
        BK_ROOT   = 4'b0100,
        BK_HOLD   = 4'b1000
    } bk_state_t;

    bk_state_t         state_reg, state_next;
    job_t              job_reg, job_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [7:0]        root_reg, root_next;
    logic [7:0]        bit_reg, bit_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_border_reg, res_border_next;
    logic [7:0]        res_mag_reg, res_mag_next;
    logic              res_end_reg, res_end_next;

    logic signed [2*GX_W-1:0] gx_sq;
    logic signed [2*GX_W-1:0] gy_sq;
    logic [7:0]               trial;
    logic [15:0]              trial_sq;

    assign gx_sq    = job_reg.gx * job_reg.gx;
    assign gy_sq    = job_reg.gy * job_reg.gy;
    assign trial    = root_reg | bit_reg;
    assign trial_sq = 16'(trial) * 16'(trial);
    assign job_pop  = (state_reg == BK_IDLE) && !job_empty;

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        sq_next         = sq_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        res_valid_next  = res_valid_reg;
        res_border_next = res_border_reg;
        res_mag_next    = res_mag_reg;
        res_end_next    = res_end_reg;

        if (pop && res_valid_reg)
            res_valid_next = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_next   = job_in;
                    state_next = job_in.border ? BK_HOLD : BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                sq_next    = SQ_W'(gx_sq[SQ_W-1:0]) + SQ_W'(gy_sq[SQ_W-1:0]);
                root_next  = 8'd0;
                bit_next   = 8'h80;
                state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                if (SQ_W'(trial_sq) <= sq_reg)
                    root_next = trial;
                bit_next = bit_reg >> 1;
                if (bit_reg[0])
                    state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_valid_next  = 1'b1;
                    res_border_next = job_reg.border;
                    res_mag_next    = root_reg;
                    res_end_next    = job_reg.frame_end;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign empty     = !res_valid_reg;
    assign out_byte0 = res_border_reg ? BORDER0 : res_mag_reg;
    assign out_byte1 = res_border_reg ? BORDER1 : res_mag_reg;
    assign out_byte2 = res_border_reg ? BORDER2 : res_mag_reg;
    assign out_byte3 = res_border_reg ? BORDER3 : res_mag_reg;
    assign frame_end = res_end_reg;

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        sq_reg         <= sq_next;
        root_reg       <= root_next;
        bit_reg        <= bit_next;
        res_border_reg <= res_border_next;
        res_mag_reg    <= res_mag_next;
        res_end_reg    <= res_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

FILE: src/prewitt_edge_magnitude.sv
// output order: the result for a pixel is triggered by the transfer of the pixel frame_width+1
// later (or a flush) and then passes through the job queue and the result engine
// throughput: input takes one item per cycle while the job queue has room; the result side
// finishes each job before taking the next: square, then one root bit per cycle, none for borders
// reset: async active low; 640x480 geometry, empty pipeline, line stores read as zero
// until written (fill count, no clearing pass)
module prewitt_edge_magnitude
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   operation,
    input  logic [7:0]             chan_blue,
    input  logic [7:0]             chan_green,
    input  logic [7:0]             chan_red,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             out_byte0,
    output logic [7:0]             out_byte1,
    output logic [7:0]             out_byte2,
    output logic [7:0]             out_byte3,
    output logic                   frame_end,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic              job_push;
    job_t              job_wr;
    job_t              job_rd;
    logic              job_pop;
    logic              job_empty;
    logic [QLVL_W-1:0] q_level;

    pem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .chan_blue  (chan_blue),
        .chan_green (chan_green),
        .chan_red   (chan_red),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_level    (q_level),
        .job_push   (job_push),
        .job        (job_wr)
    );

    pem_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_wr),
        .rd_en  (job_pop),
        .rd_job (job_rd),
        .empty  (job_empty),
        .level  (q_level)
    );

    pem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_in    (job_rd),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte0 (out_byte0),
        .out_byte1 (out_byte1),
        .out_byte2 (out_byte2),
        .out_byte3 (out_byte3),
        .frame_end (frame_end)
    );

endmodule
